// ===== rtl/sselfp_pkg.sv =====
// Shared types, character codes and field-name tables for the event-stream parser.
package sselfp_pkg;

    // Character codes that steer the parser.
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Retry magnitude limits and the value that means no retry.
    localparam logic [31:0] RETRY_MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] RETRY_POS_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] RETRY_NONE      = 32'hFFFF_FFFF;

    // Token kinds carried on the result channel.
    typedef enum logic [2:0] {
        TOK_DATA_BYTE   = 3'd0,
        TOK_DATA_BREAK  = 3'd1,
        TOK_EVENT_CLEAR = 3'd2,
        TOK_EVENT_BYTE  = 3'd3,
        TOK_ID_CLEAR    = 3'd4,
        TOK_ID_BYTE     = 3'd5,
        TOK_DISPATCH    = 3'd6
    } tok_kind_t;

    // Position within the current line.
    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_NAME    = 2'd1,
        PH_VALUE   = 2'd2,
        PH_COMMENT = 2'd3
    } line_phase_t;

    // Field that the current line carries.
    typedef enum logic [2:0] {
        FK_NONE  = 3'd0,
        FK_DATA  = 3'd1,
        FK_EVENT = 3'd2,
        FK_ID    = 3'd3,
        FK_RETRY = 3'd4
    } field_kind_t;

    // Progress of the decimal retry parse.
    typedef enum logic [1:0] {
        RP_SKIP   = 2'd0,
        RP_SIGN   = 2'd1,
        RP_DIGITS = 2'd2,
        RP_STOP   = 2'd3
    } retry_phase_t;

    // Retry parse state passed between the top level and the retry parser.
    typedef struct packed {
        retry_phase_t phase;
        logic         negative;
        logic [31:0]  accum;
    } retry_state_t;

    // Field names, one per match bit, padded with zeros to eight characters.
    localparam int NUM_NAMES = 4;
    localparam logic [7:0] NAME_CHARS [NUM_NAMES][8] = '{
        '{8'h64, 8'h61, 8'h74, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h76, 8'h65, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h69, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h72, 8'h65, 8'h74, 8'h72, 8'h79, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{3'd4, 3'd5, 3'd2, 3'd5};
    localparam field_kind_t NAME_KIND [NUM_NAMES] = '{FK_DATA, FK_EVENT, FK_ID, FK_RETRY};

    // Signed retry value from a sign and a magnitude, clamped to the positive limit.
    function automatic logic [31:0] retry_commit_value(input logic negative,
                                                       input logic [31:0] accum);
        logic [31:0] result;
        begin
            if (negative)
                result = 32'd0 - accum;
            else if (accum > RETRY_POS_MAX)
                result = RETRY_POS_MAX;
            else
                result = accum;
            return result;
        end
    endfunction

endpackage

// ===== rtl/sselfp_if.sv =====
// Valid/ready channel interfaces for the stream bytes and the result tokens.
interface sselfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;

    modport source (output valid, output byte_value, input ready);
    modport sink (input valid, input byte_value, output ready);
endinterface

interface sselfp_token_if;
    import sselfp_pkg::*;

    logic        valid;
    logic        ready;
    tok_kind_t   token_kind;
    logic [7:0]  token_byte;
    logic        dispatch_has_id;
    logic        dispatch_has_retry;
    logic signed [31:0] dispatch_retry_ms;

    modport source (
        output valid, output token_kind, output token_byte, output dispatch_has_id,
        output dispatch_has_retry, output dispatch_retry_ms, input ready
    );
    modport sink (
        input valid, input token_kind, input token_byte, input dispatch_has_id,
        input dispatch_has_retry, input dispatch_retry_ms, output ready
    );
endinterface

// ===== rtl/sselfp_retry.sv =====
// Next-state logic of the decimal retry parser for one value byte.
module sselfp_retry (
    input  sselfp_pkg::retry_state_t state,
    input  logic [7:0]               byte_value,
    output sselfp_pkg::retry_state_t state_next,
    output logic                     commit
);
    import sselfp_pkg::*;

    logic        is_digit;
    logic        is_blank;
    logic [3:0]  digit_value;
    logic [35:0] scaled;

    assign is_digit    = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
    assign is_blank    = (byte_value == CH_SPACE) || (byte_value == CH_TAB) ||
                         (byte_value == CH_VT) || (byte_value == CH_FF);
    assign digit_value = 4'(byte_value - CH_ZERO);

    // Ten times the magnitude plus the new digit, built from two shifts.
    assign scaled = {1'b0, state.accum, 3'b000} + {3'b000, state.accum, 1'b0}
                  + {32'd0, digit_value};

    // Skip blanks, take a sign, then collect digits until the first other byte.
    always_comb
    begin
        state_next = state;
        commit     = 1'b0;
        unique case (state.phase)
            RP_SKIP:
            begin
                if (is_blank)
                begin
                    state_next.phase = RP_SKIP;
                end
                else if ((byte_value == CH_PLUS) || (byte_value == CH_MINUS))
                begin
                    state_next.negative = (byte_value == CH_MINUS);
                    state_next.phase    = RP_SIGN;
                end
                else if (is_digit)
                begin
                    state_next.accum = {28'd0, digit_value};
                    state_next.phase = RP_DIGITS;
                end
                else
                begin
                    state_next.phase = RP_STOP;
                end
            end
            RP_SIGN:
            begin
                if (is_digit)
                begin
                    state_next.accum = {28'd0, digit_value};
                    state_next.phase = RP_DIGITS;
                end
                else
                begin
                    state_next.phase = RP_STOP;
                end
            end
            RP_DIGITS:
            begin
                if (is_digit)
                begin
                    if (scaled > {4'd0, RETRY_MAG_LIMIT})
                        state_next.accum = RETRY_MAG_LIMIT;
                    else
                        state_next.accum = scaled[31:0];
                end
                else
                begin
                    commit           = 1'b1;
                    state_next.phase = RP_STOP;
                end
            end
            RP_STOP:
            begin
                state_next.phase = RP_STOP;
            end
            default:
            begin
                state_next.phase = RP_STOP;
            end
        endcase
    end

endmodule

// ===== rtl/sse_line_field_parser.sv =====
// Top level of the event-stream line and field parser.
//
// The block takes one raw event-stream byte per beat on the stream channel and
// gives at most one token per byte on the tokens channel. Lines end on CR, LF
// or CRLF (an LF straight after a CR is dropped, even after a pause). Comment
// lines give nothing; data, event and id lines stream their value as byte
// tokens after a clear token (event, id) or a break token (data already seen);
// a blank line gives a dispatch token with the id flag and the parsed retry value.
// An accepted byte waits in the input register and is parsed from there; its token
// is loaded into the token register as soon as that register is free.
// Throughput: one byte per clock while tokens are taken, set by the single parse
// stage between the input and token registers; bytes that give no token leave no gap.
// When the receiver stalls, the token register holds its beat and the input
// register takes one more byte, after which stream.ready falls until the
// token is taken. Reset clears both registers and returns the parser to the
// start of a line with no data, no id and no retry held.
module sse_line_field_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    sselfp_byte_if.sink           stream,
    sselfp_token_if.source        tokens
);
    import sselfp_pkg::*;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  byte_reg;

    // Parser state.
    line_phase_t  line_phase_reg, line_phase_next;
    logic         after_cr_reg, after_cr_next;
    logic [3:0]   name_match_reg, name_match_next;
    logic [2:0]   name_length_reg, name_length_next;
    field_kind_t  field_kind_reg, field_kind_next;
    logic         space_pending_reg, space_pending_next;
    logic         data_seen_reg, data_seen_next;
    logic         id_seen_reg, id_seen_next;
    retry_state_t retry_reg, retry_next;
    logic [31:0]  retry_held_reg, retry_held_next;
    logic         retry_held_valid_reg, retry_held_valid_next;

    // Token register.
    logic         out_valid_reg;
    tok_kind_t    kind_reg, kind_next;
    logic [7:0]   tbyte_reg, tbyte_next;
    logic         has_id_reg, has_id_next;
    logic         has_retry_reg, has_retry_next;
    logic [31:0]  retry_val_reg, retry_val_next;
    logic         emit;

    logic         out_free;
    logic         advance;
    logic         is_lf;
    logic         is_cr;
    field_kind_t  resolved_kind;
    logic [31:0]  commit_value;
    retry_state_t retry_char_next;
    logic         retry_char_commit;
    logic         retry_line_reset;

    assign out_free     = !out_valid_reg || tokens.ready;
    assign advance      = in_valid_reg && out_free;
    assign stream.ready = !in_valid_reg || advance;

    assign is_lf = (byte_reg == CH_LF);
    assign is_cr = (byte_reg == CH_CR);

    assign commit_value = retry_commit_value(retry_reg.negative, retry_reg.accum);

    // Field that the collected name selects.
    always_comb
    begin
        resolved_kind = FK_NONE;
        for (int k = 0; k < NUM_NAMES; k++)
        begin
            if (name_match_reg[k] && (name_length_reg == NAME_LEN[k]))
                resolved_kind = NAME_KIND[k];
        end
    end

    sselfp_retry u_retry (
        .state      (retry_reg),
        .byte_value (byte_reg),
        .state_next (retry_char_next),
        .commit     (retry_char_commit)
    );

    // One byte of parsing: line ends, name collection and value tokens.
    always_comb
    begin
        line_phase_next       = line_phase_reg;
        after_cr_next         = after_cr_reg;
        name_match_next       = name_match_reg;
        name_length_next      = name_length_reg;
        field_kind_next       = field_kind_reg;
        space_pending_next    = space_pending_reg;
        data_seen_next        = data_seen_reg;
        id_seen_next          = id_seen_reg;
        retry_next            = retry_reg;
        retry_held_next       = retry_held_reg;
        retry_held_valid_next = retry_held_valid_reg;
        retry_line_reset      = 1'b0;
        emit                  = 1'b0;
        kind_next             = TOK_DATA_BYTE;
        tbyte_next            = 8'd0;
        has_id_next           = 1'b0;
        has_retry_next        = 1'b0;
        retry_val_next        = 32'd0;

        if (is_lf && after_cr_reg)
        begin
            after_cr_next = 1'b0;
        end
        else if (is_cr || is_lf)
        begin
            after_cr_next = is_cr;
            unique case (line_phase_reg)
                PH_START:
                begin
                    emit                  = 1'b1;
                    kind_next             = TOK_DISPATCH;
                    has_id_next           = id_seen_reg;
                    has_retry_next        = retry_held_valid_reg;
                    retry_val_next        = retry_held_valid_reg ? retry_held_reg : RETRY_NONE;
                    data_seen_next        = 1'b0;
                    id_seen_next          = 1'b0;
                    retry_held_next       = RETRY_NONE;
                    retry_held_valid_next = 1'b0;
                end
                PH_NAME:
                begin
                    if ((resolved_kind == FK_DATA) && data_seen_reg)
                    begin
                        emit      = 1'b1;
                        kind_next = TOK_DATA_BREAK;
                    end
                    else if (resolved_kind == FK_EVENT)
                    begin
                        emit      = 1'b1;
                        kind_next = TOK_EVENT_CLEAR;
                    end
                    else if (resolved_kind == FK_ID)
                    begin
                        emit         = 1'b1;
                        kind_next    = TOK_ID_CLEAR;
                        id_seen_next = 1'b0;
                    end
                end
                PH_VALUE:
                begin
                    if ((field_kind_reg == FK_RETRY) && (retry_reg.phase == RP_DIGITS))
                    begin
                        retry_held_next       = commit_value;
                        retry_held_valid_next = 1'b1;
                    end
                end
                PH_COMMENT:
                begin
                    emit = 1'b0;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
            // Every line end starts a fresh line.
            line_phase_next    = PH_START;
            name_match_next    = 4'hF;
            name_length_next   = 3'd0;
            field_kind_next    = FK_NONE;
            space_pending_next = 1'b0;
            retry_line_reset   = 1'b1;
        end
        else
        begin
            after_cr_next = 1'b0;
            if ((line_phase_reg == PH_START) && (byte_reg == CH_COLON))
            begin
                line_phase_next = PH_COMMENT;
            end
            else if ((line_phase_reg == PH_START) || (line_phase_reg == PH_NAME))
            begin
                line_phase_next = PH_NAME;
                if (byte_reg == CH_COLON)
                begin
                    // The name ends at its colon and the value opens.
                    line_phase_next    = PH_VALUE;
                    space_pending_next = 1'b1;
                    field_kind_next    = resolved_kind;
                    if ((resolved_kind == FK_DATA) && data_seen_reg)
                    begin
                        emit      = 1'b1;
                        kind_next = TOK_DATA_BREAK;
                    end
                    else if (resolved_kind == FK_EVENT)
                    begin
                        emit      = 1'b1;
                        kind_next = TOK_EVENT_CLEAR;
                    end
                    else if (resolved_kind == FK_ID)
                    begin
                        emit         = 1'b1;
                        kind_next    = TOK_ID_CLEAR;
                        id_seen_next = 1'b0;
                    end
                end
                else
                begin
                    // Drop every name that this character rules out.
                    for (int k = 0; k < NUM_NAMES; k++)
                    begin
                        if ((name_length_reg >= NAME_LEN[k]) ||
                            (NAME_CHARS[k][name_length_reg] != byte_reg))
                            name_match_next[k] = 1'b0;
                    end
                    if (name_length_reg != 3'd7)
                        name_length_next = name_length_reg + 3'd1;
                end
            end
            else if (line_phase_reg == PH_VALUE)
            begin
                space_pending_next = 1'b0;
                if (!(space_pending_reg && (byte_reg == CH_SPACE)))
                begin
                    unique case (field_kind_reg)
                        FK_DATA:
                        begin
                            emit           = 1'b1;
                            kind_next      = TOK_DATA_BYTE;
                            tbyte_next     = byte_reg;
                            data_seen_next = 1'b1;
                        end
                        FK_EVENT:
                        begin
                            emit       = 1'b1;
                            kind_next  = TOK_EVENT_BYTE;
                            tbyte_next = byte_reg;
                        end
                        FK_ID:
                        begin
                            emit         = 1'b1;
                            kind_next    = TOK_ID_BYTE;
                            tbyte_next   = byte_reg;
                            id_seen_next = 1'b1;
                        end
                        FK_RETRY:
                        begin
                            retry_next = retry_char_next;
                            if (retry_char_commit)
                            begin
                                retry_held_next       = commit_value;
                                retry_held_valid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
        end

        if (retry_line_reset)
        begin
            retry_next.phase    = RP_SKIP;
            retry_next.negative = 1'b0;
            retry_next.accum    = 32'd0;
        end
    end

    // Input register: takes a beat whenever it is empty or being consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.valid && stream.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
            byte_reg <= stream.byte_value;
    end

    // Parser state moves on each time a byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_phase_reg       <= PH_START;
            after_cr_reg         <= 1'b0;
            name_match_reg       <= 4'hF;
            name_length_reg      <= 3'd0;
            field_kind_reg       <= FK_NONE;
            space_pending_reg    <= 1'b0;
            data_seen_reg        <= 1'b0;
            id_seen_reg          <= 1'b0;
            retry_reg            <= '{phase: RP_SKIP, negative: 1'b0, accum: 32'd0};
            retry_held_reg       <= RETRY_NONE;
            retry_held_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            line_phase_reg       <= line_phase_next;
            after_cr_reg         <= after_cr_next;
            name_match_reg       <= name_match_next;
            name_length_reg      <= name_length_next;
            field_kind_reg       <= field_kind_next;
            space_pending_reg    <= space_pending_next;
            data_seen_reg        <= data_seen_next;
            id_seen_reg          <= id_seen_next;
            retry_reg            <= retry_next;
            retry_held_reg       <= retry_held_next;
            retry_held_valid_reg <= retry_held_valid_next;
        end
    end

    // Token register: loads a beat when a byte gives one, clears when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (tokens.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            kind_reg      <= kind_next;
            tbyte_reg     <= tbyte_next;
            has_id_reg    <= has_id_next;
            has_retry_reg <= has_retry_next;
            retry_val_reg <= retry_val_next;
        end
    end

    assign tokens.valid              = out_valid_reg;
    assign tokens.token_kind         = kind_reg;
    assign tokens.token_byte         = tbyte_reg;
    assign tokens.dispatch_has_id    = has_id_reg;
    assign tokens.dispatch_has_retry = has_retry_reg;
    assign tokens.dispatch_retry_ms  = retry_val_reg;

endmodule
